### hw/rtl/srf_pkg.sv
// shared types and constants for the spectral rolloff finder
// no dependencies; imported by every module of the block except srf_ram
`default_nettype none

package srf_pkg;

  localparam int MAX_BINS   = 1024;
  localparam int MAG_BITS   = 16;
  localparam int IN_TDATA_W = 16;
  localparam int ADDR_W     = $clog2(MAX_BINS);
  localparam int CNT_W      = $clog2(MAX_BINS + 1);
  localparam int TOT_W      = MAG_BITS + ADDR_W;
  localparam int PCT_W      = 7;
  localparam int PROD_W     = TOT_W + PCT_W;
  localparam int FRAC_W     = 16;
  localparam int STEP_W     = $clog2(FRAC_W);
  localparam int OUT_RAW_W  = ADDR_W + CNT_W + FRAC_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [PCT_W-1:0] CUTOFF_RESET = PCT_W'(85);
  localparam logic [6:0]       SCALE        = 7'd100;

  // one finished frame waiting for the walk
  typedef struct packed {
    logic [TOT_W-1:0] total;
    logic [CNT_W-1:0] count;
    logic             dropped;
    logic             bank;
  } frame_desc_t;

  typedef struct packed {
    logic                we;
    logic                bank;
    logic [ADDR_W-1:0]   addr;
    logic [MAG_BITS-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic              bank;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rolloff_bin;
    logic [CNT_W-1:0]  bin_count;
    logic [FRAC_W-1:0] rolloff_fraction;
    logic              overflow;
  } result_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_WALK,
    B_DIV,
    B_OUT
  } back_state_e;

endpackage

`default_nettype wire

### hw/rtl/srf_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module srf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/srf_front.sv
// front end: accepts bins, writes them into the current bank, totals them
// depends on srf_pkg; hands each finished frame to srf_queue
`default_nettype none

module srf_front
  import srf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_valid_i,
  output logic                       s_ready_o,
  input  wire logic [MAG_BITS-1:0]   s_mag_i,
  input  wire logic                  s_last_i,
  input  wire logic                  q_full_i,
  output logic                       push_o,
  output frame_desc_t                push_desc_o,
  output ram_wr_t                    ram_wr_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic             drop_q, drop_d;
  logic             bank_q, bank_d;
  logic             accept;
  logic             room;
  logic [CNT_W-1:0] count_new;
  logic [TOT_W-1:0] total_new;
  logic             drop_new;

  // a full queue means both banks hold frames the back end has not yet finished
  assign s_ready_o = !q_full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign room      = count_q < CNT_W'(MAX_BINS);

  always_comb begin
    count_new = count_q;
    total_new = total_q;
    drop_new  = drop_q;
    if (room) begin
      count_new = count_q + CNT_W'(1);
      total_new = total_q + TOT_W'(s_mag_i);
    end else begin
      drop_new = 1'b1;
    end

    count_d = count_q;
    total_d = total_q;
    drop_d  = drop_q;
    bank_d  = bank_q;
    if (accept) begin
      if (s_last_i) begin
        count_d = '0;
        total_d = '0;
        drop_d  = 1'b0;
        bank_d  = !bank_q;
      end else begin
        count_d = count_new;
        total_d = total_new;
        drop_d  = drop_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      drop_q  <= 1'b0;
      bank_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      total_q <= total_d;
      drop_q  <= drop_d;
      bank_q  <= bank_d;
    end
  end

  assign ram_wr_o.we   = accept && room;
  assign ram_wr_o.bank = bank_q;
  assign ram_wr_o.addr = count_q[ADDR_W-1:0];
  assign ram_wr_o.data = s_mag_i;

  assign push_o              = accept && s_last_i;
  assign push_desc_o.total   = total_new;
  assign push_desc_o.count   = count_new;
  assign push_desc_o.dropped = drop_new;
  assign push_desc_o.bank    = bank_q;

endmodule

`default_nettype wire

### hw/rtl/srf_queue.sv
// short fifo of frame descriptors between front end and back end
// depends on srf_pkg
`default_nettype none

module srf_queue
  import srf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire frame_desc_t  push_desc_i,
  input  wire logic         pop_i,
  output logic              full_o,
  output logic              empty_o,
  output frame_desc_t       head_o
);

  frame_desc_t       entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == QCNT_W'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/srf_back.sv
// back end: walks a stored frame, finds the rolloff bin, divides, holds result
// depends on srf_pkg; reads the bin banks and pops srf_queue
`default_nettype none

module srf_back
  import srf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [PCT_W-1:0]    cutoff_i,
  input  wire logic                q_empty_i,
  input  wire frame_desc_t         q_head_i,
  output logic                     pop_o,
  output ram_rd_t                  ram_rd_o,
  input  wire logic [MAG_BITS-1:0] rdata0_i,
  input  wire logic [MAG_BITS-1:0] rdata1_i,
  output logic                     m_valid_o,
  input  wire logic                m_ready_i,
  output result_t                  m_result_o
);

  back_state_e state_q, state_d;

  logic [PROD_W-1:0] target_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              ovf_q;
  logic              bank_q;
  logic [CNT_W-1:0]  rd_idx_q;
  logic              p1_v_q, p2_v_q, p3_v_q;
  logic [ADDR_W-1:0] p1_idx_q, p2_idx_q, p3_idx_q;
  logic [PROD_W-1:0] scaled_q;
  logic [PROD_W-1:0] acc_q;
  logic              found_q;
  logic [ADDR_W-1:0] found_idx_q;
  logic [CNT_W-1:0]  rem_q;
  logic [FRAC_W-1:0] quo_q;
  logic [STEP_W-1:0] step_q;
  logic              m_valid_q;
  result_t           result_q;

  logic              issue;
  logic              walk_done;
  logic              div_done;
  logic              out_free;
  logic              start;
  logic [MAG_BITS-1:0] rdata;
  logic [CNT_W:0]    rem_x2;
  logic              q_bit;
  logic [CNT_W-1:0]  rem_next;
  logic [ADDR_W-1:0] rolloff;

  assign issue     = (state_q == B_WALK) && (rd_idx_q < cnt_q);
  assign walk_done = (state_q == B_WALK) && (rd_idx_q == cnt_q)
                     && !p1_v_q && !p2_v_q && !p3_v_q;
  assign div_done  = (state_q == B_DIV) && (step_q == STEP_W'(FRAC_W - 1));
  assign out_free  = !m_valid_q || m_ready_i;
  assign rdata     = bank_q ? rdata1_i : rdata0_i;
  assign rolloff   = found_q ? found_idx_q : '0;

  // restoring divide step, remainder always stays below the count
  assign rem_x2   = {rem_q, 1'b0};
  assign q_bit    = rem_x2 >= {1'b0, cnt_q};
  assign rem_next = q_bit ? CNT_W'(rem_x2 - {1'b0, cnt_q}) : rem_x2[CNT_W-1:0];

  always_comb begin
    state_d = state_q;
    start   = 1'b0;
    pop_o   = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          start   = 1'b1;
          state_d = B_WALK;
        end
      end
      B_WALK: begin
        if (walk_done) begin
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        if (div_done) begin
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (out_free) begin
          pop_o   = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      p1_v_q    <= 1'b0;
      p2_v_q    <= 1'b0;
      p3_v_q    <= 1'b0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      p1_v_q  <= issue;
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      if (start) begin
        found_q <= 1'b0;
      end else if (p3_v_q && !found_q && (acc_q > target_q)) begin
        found_q <= 1'b1;
      end
      if (pop_o) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      target_q <= PROD_W'(cutoff_i) * PROD_W'(q_head_i.total);
      cnt_q    <= q_head_i.count;
      ovf_q    <= q_head_i.dropped;
      bank_q   <= q_head_i.bank;
      rd_idx_q <= '0;
      acc_q    <= '0;
    end else begin
      if (issue) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
      if (p2_v_q) begin
        acc_q <= acc_q + scaled_q;
      end
    end
    p1_idx_q <= rd_idx_q[ADDR_W-1:0];
    p2_idx_q <= p1_idx_q;
    p3_idx_q <= p2_idx_q;
    scaled_q <= PROD_W'(rdata) * PROD_W'(SCALE);
    if (p3_v_q && !found_q) begin
      found_idx_q <= p3_idx_q;
    end
    if (walk_done) begin
      rem_q  <= CNT_W'(rolloff);
      quo_q  <= '0;
      step_q <= '0;
    end else if (state_q == B_DIV) begin
      rem_q  <= rem_next;
      quo_q  <= {quo_q[FRAC_W-2:0], q_bit};
      step_q <= step_q + STEP_W'(1);
    end
    if (pop_o) begin
      result_q.rolloff_bin      <= rolloff;
      result_q.bin_count        <= cnt_q;
      result_q.rolloff_fraction <= quo_q;
      result_q.overflow         <= ovf_q;
    end
  end

  assign ram_rd_o.re   = issue;
  assign ram_rd_o.bank = bank_q;
  assign ram_rd_o.addr = rd_idx_q[ADDR_W-1:0];

  assign m_valid_o  = m_valid_q;
  assign m_result_o = result_q;

endmodule

`default_nettype wire

### hw/rtl/spectral_rolloff_finder_core.sv
// top level of the spectral rolloff finder: front end, descriptor queue,
// back end and two bin banks; depends on srf_pkg and all srf_* modules
`default_nettype none

// Spectral rolloff finder. Bins of one frame arrive one per transfer on the
// slave stream, tlast on the final bin. For each frame one result transfer
// leaves on the master stream: the first bin index whose running sum times
// 100 exceeds cutoff_percent times the frame total (0 if none), the number of
// stored bins and index/count as an unsigned Q0.16 fraction truncated toward
// zero. Bins past MAX_BINS are dropped and flagged in tuser. Bins are taken at
// one per cycle into one of two bin banks while the back end walks the other
// bank; for a frame of N bins the back end does N reads through a four-stage
// read/scale/accumulate/compare pipe, a 16-bit restoring divide and a result
// handoff. Input is held off only while both banks carry frames the back end
// has not yet finished. cutoff_percent is written through the cfg channel,
// always ready, and must only change while no frame is in flight.
module spectral_rolloff_finder_core
  import srf_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write: cutoff_percent
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [PCT_W-1:0]       cfg_data_i,
  // bin stream in
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] magnitude
  input  wire logic                   s_axis_tlast,  // last_bin
  // result stream out
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // rolloff_bin, bin_count,
                                                     // rolloff_fraction, zero pad
  output logic [0:0]                  m_axis_tuser   // overflow
);

  logic [PCT_W-1:0] cutoff_q;

  // push/pop between the two halves
  logic        q_push, q_pop, q_full, q_empty;
  frame_desc_t q_push_desc, q_head;

  ram_wr_t             ram_wr;
  ram_rd_t             ram_rd;
  logic [MAG_BITS-1:0] rdata0, rdata1;
  result_t             result;

  // cutoff register, written whenever a cfg transfer happens
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RESET;
    end else if (cfg_valid_i) begin
      cutoff_q <= cfg_data_i;
    end
  end

  srf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_mag_i     (s_axis_tdata[MAG_BITS-1:0]),
    .s_last_i    (s_axis_tlast),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_desc_o (q_push_desc),
    .ram_wr_o    (ram_wr)
  );

  srf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (q_push_desc),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  // two banks, front writes one while back reads the other
  srf_ram #(
    .WIDTH (MAG_BITS),
    .DEPTH (MAX_BINS)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we && !ram_wr.bank),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_rd.re && !ram_rd.bank),
    .raddr_i (ram_rd.addr),
    .rdata_o (rdata0)
  );

  srf_ram #(
    .WIDTH (MAG_BITS),
    .DEPTH (MAX_BINS)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we && ram_wr.bank),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_rd.re && ram_rd.bank),
    .raddr_i (ram_rd.addr),
    .rdata_o (rdata1)
  );

  srf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cutoff_i   (cutoff_q),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .pop_o      (q_pop),
    .ram_rd_o   (ram_rd),
    .rdata0_i   (rdata0),
    .rdata1_i   (rdata1),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_result_o (result)
  );

  assign m_axis_tdata = OUT_TDATA_W'({result.rolloff_fraction, result.bin_count,
                                      result.rolloff_bin});
  assign m_axis_tuser = result.overflow;

`ifndef SYNTHESIS
  // the walk never reads the bank that is being filled
  a_bank_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_wr.we && ram_rd.re) |-> (ram_wr.bank != ram_rd.bank))
    else $error("front end writes the bank under walk");

  // a finished frame only enters the queue when there is a free slot
  a_no_queue_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("descriptor queue overrun");

  // the rolloff index always lies inside the stored frame
  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (CNT_W'(result.rolloff_bin) < result.bin_count))
    else $error("rolloff index beyond bin count");
`endif

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for spectral_rolloff_finder_core: drives bin frames and
// cutoff writes, predicts each frame's rolloff result and checks it; uses srf_pkg

module tb_top;
  import srf_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_WAIT  = 48;          // idle time for the back end after the last result drains
  localparam int BIN_LSB      = 0;
  localparam int CNT_LSB      = ADDR_W;
  localparam int FRAC_LSB     = ADDR_W + CNT_W;
  localparam logic [MAG_BITS-1:0] MAG_TOP = {MAG_BITS{1'b1}};

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_LOW,
    FILL_SPARSE,
    FILL_MAX,
    FILL_RAMP
  } fill_kind_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [PCT_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [15:0] magnitude
  logic                   s_axis_tlast  = 1'b0;  // last_bin
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // rolloff_bin, bin_count, rolloff_fraction, pad
  logic [0:0]             m_axis_tuser;  // overflow

  spectral_rolloff_finder_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // predictor copy of the block state
  logic [MAG_BITS-1:0] mag_mem [MAX_BINS];
  logic [TOT_W-1:0]    energy_sum = '0;
  int                  bins_held  = 0;
  logic                bins_lost  = 1'b0;
  logic [PCT_W-1:0]    cutoff_pct = CUTOFF_RESET;
  result_t             rolloff_expect [$];

  int  err_count    = 0;
  int  cycle_count  = 0;
  int  result_count = 0;
  int  hold_request = 0;
  bit  src_gaps     = 1'b1;
  bit  sink_stalls  = 1'b1;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             rolloff_expect.size());
    $display("Simulation FAILED");
    $finish;
  end

  // walk the held bins for the first index whose running share beats the cutoff
  function automatic result_t close_frame();
    longint unsigned run_sum;
    longint unsigned goal;
    longint unsigned frac;
    int              hit;
    int              k;
    result_t         r;
    run_sum = 0;
    goal    = longint'(cutoff_pct) * longint'(energy_sum);
    hit     = 0;
    for (k = 0; k < bins_held; k++) begin
      run_sum += mag_mem[k];
      if (run_sum * 100 > goal) begin
        hit = k;
        break;
      end
    end
    frac = (bins_held != 0) ? (longint'(hit) << FRAC_W) / bins_held : 0;
    r.rolloff_bin      = hit[ADDR_W-1:0];
    r.bin_count        = bins_held[CNT_W-1:0];
    r.rolloff_fraction = frac[FRAC_W-1:0];
    r.overflow         = bins_lost;
    return r;
  endfunction

  // input side monitor: cutoff writes and accepted bins
  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) cutoff_pct = cfg_data_i;
    if (s_axis_tvalid && s_axis_tready) begin
      if (bins_held < MAX_BINS) begin
        mag_mem[bins_held] = s_axis_tdata[MAG_BITS-1:0];
        energy_sum += s_axis_tdata[MAG_BITS-1:0];
        bins_held++;
      end else begin
        bins_lost = 1'b1;
      end
      if (s_axis_tlast) begin
        rolloff_expect.push_back(close_frame());
        energy_sum = '0;
        bins_held  = 0;
        bins_lost  = 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("cycle %0d result %0d: %s got %0d expected %0d", cycle_count, result_count,
             what, got, want);
    err_count++;
  endtask

  // output side: every result transfer against the oldest pending frame
  always @(posedge clk_i) begin
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (rolloff_expect.size() == 0) begin
        report_mismatch("result with no frame pending", m_axis_tdata[ADDR_W-1:0], 0);
      end else begin
        want = rolloff_expect.pop_front();
        if (m_axis_tdata[BIN_LSB +: ADDR_W] !== want.rolloff_bin)
          report_mismatch("rolloff_bin", m_axis_tdata[BIN_LSB +: ADDR_W], want.rolloff_bin);
        if (m_axis_tdata[CNT_LSB +: CNT_W] !== want.bin_count)
          report_mismatch("bin_count", m_axis_tdata[CNT_LSB +: CNT_W], want.bin_count);
        if (m_axis_tdata[FRAC_LSB +: FRAC_W] !== want.rolloff_fraction)
          report_mismatch("rolloff_fraction", m_axis_tdata[FRAC_LSB +: FRAC_W],
                          want.rolloff_fraction);
        if (m_axis_tuser[0] !== want.overflow)
          report_mismatch("overflow", m_axis_tuser[0], want.overflow);
      end
      result_count++;
    end
  end

  // result receiver: long hold on request, otherwise random stall bursts
  initial begin
    forever begin
      if (hold_request != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_request) @(posedge clk_i);
        hold_request = 0;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_bin(input logic [MAG_BITS-1:0] mag, input logic last);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= mag;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [MAG_BITS-1:0] pick_magnitude(input fill_kind_e kind,
                                                         input int pos, input int len);
    case (kind)
      FILL_ZERO:   return '0;
      FILL_LOW:    return MAG_BITS'($urandom_range(0, 3));
      FILL_SPARSE: return ($urandom_range(0, 7) == 0) ? MAG_BITS'($urandom) : '0;
      FILL_MAX:    return MAG_TOP;
      FILL_RAMP:   return MAG_BITS'((len - pos) * 300);
      default:     return MAG_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_frame(input int len, input fill_kind_e kind);
    int i;
    for (i = 0; i < len; i++) send_bin(pick_magnitude(kind, i, len), i == len - 1);
  endtask

  // stop offering, let every pending result drain, then allow the back end to settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (rolloff_expect.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_cutoff(input logic [PCT_W-1:0] pct);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= pct;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // short frames at reset cutoff, then cutoff zero, cutoff at and above 100
  task automatic test_directed_cases();
    send_bin(MAG_TOP, 1'b1);                     // single bin frame
    send_frame(3, FILL_ZERO);                     // all zero: index 0
    send_frame(7, FILL_RAMP);
    send_bin(16'd1, 1'b0);                        // truncated fraction on count 3
    send_bin(16'd0, 1'b0);
    send_bin(16'd2, 1'b1);
    send_bin(16'd0, 1'b0);                        // energy only in the last bin
    send_bin(16'd0, 1'b0);
    send_bin(MAG_TOP, 1'b1);
    wait_drained();
    write_cutoff(PCT_W'(0));                      // first nonzero running sum wins
    send_bin(16'd0, 1'b0);
    send_bin(16'd0, 1'b0);
    send_bin(16'h5555, 1'b0);
    send_bin(16'hAAAA, 1'b1);
    wait_drained();
    write_cutoff(PCT_W'(100));                    // share can never be exceeded
    send_frame(2, FILL_MAX);
    wait_drained();
    write_cutoff(PCT_W'(127));
    send_frame(2, FILL_RANDOM);
    wait_drained();
  endtask

  // full store of largest bins with overflow, then a short frame to see the flag cleared
  task automatic test_store_limits();
    write_cutoff(PCT_W'(99));
    send_frame(MAX_BINS + 3, FILL_MAX);
    send_frame(3, FILL_LOW);
    wait_drained();
  endtask

  // receiver holds off long enough for both banks and the queue to fill
  task automatic test_output_backpressure();
    int i;
    write_cutoff(PCT_W'(50));
    hold_request = 2000;
    for (i = 0; i < 12; i++) send_frame(8, FILL_RANDOM);
    wait_drained();
  endtask

  task automatic test_random_frames(input int n_items, input logic [PCT_W-1:0] pct);
    int sent;
    int len;
    write_cutoff(pct);
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
      send_frame(len, fill_kind_e'($urandom_range(0, 5)));
      sent += len;
    end
    wait_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_cases();
    test_store_limits();
    test_output_backpressure();

    test_random_frames(50, PCT_W'(1));
    test_random_frames(50, PCT_W'(99));
    sink_stalls = 1'b0;
    test_random_frames(50, PCT_W'($urandom_range(1, 99)));
    sink_stalls = 1'b1;
    src_gaps    = 1'b0;
    test_random_frames(50, PCT_W'($urandom_range(1, 99)));
    src_gaps    = 1'b1;
    test_random_frames(50, CUTOFF_RESET);
    test_random_frames(50, PCT_W'($urandom_range(1, 99)));

    // closing stretch at full rate on both sides
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    test_random_frames(50, PCT_W'($urandom_range(1, 99)));

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
